// ----- src/memory_pressure_vote_monitor_assert.svh -----
// assertion macros shared by the memory pressure vote monitor rtl
`ifndef MEMORY_PRESSURE_VOTE_MONITOR_ASSERT_SVH
`define MEMORY_PRESSURE_VOTE_MONITOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MPVM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpvm assertion failed");

// consequent must hold in the cycle after the antecedent
`define MPVM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpvm assertion failed");

`endif

// ----- src/mpvm_pkg.sv -----
package mpvm_pkg;

    // field widths
    localparam int BYTES_W  = 40;
    localparam int EFF_W    = BYTES_W + 1;
    localparam int KB_W     = 31;
    localparam int Q16_W    = 17;
    localparam int CD_W     = 16;
    localparam int LEVEL_W  = 2;

    // shared multiplier: q16 ratio times one 16-bit chunk of the wide operand
    localparam int CHUNK_W  = 16;
    localparam int WIDE_W   = 3 * CHUNK_W;
    localparam int PROD_W   = Q16_W + CHUNK_W;
    localparam int ACC_W    = Q16_W + EFF_W;

    // stream packing
    localparam int IN_DATA_W  = 280;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;

    // apb
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    // register indexes
    localparam logic [2:0] REG_BUDGET        = 3'd0;
    localparam logic [2:0] REG_MODERATE_BUD  = 3'd1;
    localparam logic [2:0] REG_CRITICAL_BUD  = 3'd2;
    localparam logic [2:0] REG_MODERATE_AVL  = 3'd3;
    localparam logic [2:0] REG_CRITICAL_AVL  = 3'd4;
    localparam logic [2:0] REG_COOLDOWN      = 3'd5;

    // vote levels
    localparam logic [LEVEL_W-1:0] LVL_NONE     = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_MODERATE = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_CRITICAL = 2'd2;

    // products worked through the shared multiplier, in order
    localparam logic [1:0] OP_CRIT_BUD = 2'd0;
    localparam logic [1:0] OP_MOD_BUD  = 2'd1;
    localparam logic [1:0] OP_CRIT_AVL = 2'd2;
    localparam logic [1:0] OP_MOD_AVL  = 2'd3;

    localparam logic [1:0] LAST_CHUNK = 2'd2;

    // free + buffers + cached, saturating at the field maximum
    function automatic logic [KB_W-1:0] sat_sum3(input logic [KB_W-1:0] a,
                                                 input logic [KB_W-1:0] b,
                                                 input logic [KB_W-1:0] c);
        logic [KB_W+1:0] sum;
        sum = {2'b00, a} + {2'b00, b} + {2'b00, c};
        if (sum[KB_W+1:KB_W] != 2'b00)
            return {KB_W{1'b1}};
        else
            return sum[KB_W-1:0];
    endfunction

endpackage

// ----- src/memory_pressure_vote_monitor.sv -----
// Memory pressure vote monitor: each transfer on the slave stream is one poll tick, and each
// tick gives exactly one result transfer (level 0 none / 1 moderate / 2 critical, plus a
// notify flag) on the master stream. The block works on one tick at a time: four exact
// cross-multiplied threshold compares run through a single shared 17x16 multiplier, three
// chunks per product, each a multiply step then an accumulate step, plus one compare step
// per product; s_tready is low from acceptance until the result is loaded. A finished
// result sits in an output register, so the next tick is taken while it still waits.
// Thresholds and the cooldown are written over the APB port at byte address 8*index; the
// user must write them only while no tick is in flight, as the block does not enforce it.
module memory_pressure_vote_monitor
    import mpvm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input ticks
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // anon_bytes, resident_bytes, media_allowance, sys_total_kb, sys_available_kb,
    // sys_free_kb, sys_buffers_kb, sys_cached_kb, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // proc_info_valid, sys_info_valid
    input  logic [IN_USER_W-1:0]  s_tuser,
    // votes
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // level, notify, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [1:0]         op_reg, op_next;
    logic [1:0]         chunk_reg, chunk_next;

    // configuration registers
    logic [BYTES_W-1:0] budget_reg;
    logic [Q16_W-1:0]   mod_bud_reg;
    logic [Q16_W-1:0]   crit_bud_reg;
    logic [Q16_W-1:0]   mod_avl_reg;
    logic [Q16_W-1:0]   crit_avl_reg;
    logic [CD_W-1:0]    cooldown_reg;

    // captured tick
    logic [BYTES_W-1:0] used_reg;
    logic [EFF_W-1:0]   eff_reg;
    logic               proc_ok_reg;
    logic [KB_W-1:0]    avail_reg;
    logic [KB_W-1:0]    total_reg;
    logic               sys_ok_reg;

    // arithmetic datapath
    logic [PROD_W-1:0]  prod_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [3:0]         ge_reg;

    // vote state and output register
    logic [LEVEL_W-1:0] last_level_reg;
    logic [CD_W-1:0]    repeat_count_reg;
    logic               out_valid_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    logic               out_notify_reg;

    // unpacked input fields
    logic [BYTES_W-1:0] in_anon;
    logic [BYTES_W-1:0] in_resident;
    logic [BYTES_W-1:0] in_media;
    logic [KB_W-1:0]    in_total;
    logic [KB_W-1:0]    in_avail;
    logic [KB_W-1:0]    in_free;
    logic [KB_W-1:0]    in_buffers;
    logic [KB_W-1:0]    in_cached;
    logic [BYTES_W-1:0] in_used;
    logic [EFF_W-1:0]   in_eff;

    logic               in_xfer;
    logic               out_load;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;

    logic [Q16_W-1:0]   mul_q;
    logic [WIDE_W-1:0]  mul_wide;
    logic [CHUNK_W-1:0] mul_chunk;
    logic [PROD_W-1:0]  mul_prod;
    logic [ACC_W-1:0]   partial;
    logic [ACC_W-1:0]   cmp_lhs;
    logic               cmp_ge;

    logic [LEVEL_W-1:0] proc_level;
    logic [LEVEL_W-1:0] sys_level;
    logic [LEVEL_W-1:0] vote;
    logic [CD_W-1:0]    cooldown_eff;
    logic [CD_W-1:0]    repeat_inc;
    logic [CD_W-1:0]    repeat_count_next;
    logic               notify;

    // field unpacking
    assign in_anon     = s_tdata[39:0];
    assign in_resident = s_tdata[79:40];
    assign in_media    = s_tdata[119:80];
    assign in_total    = s_tdata[150:120];
    assign in_avail    = s_tdata[181:151];
    assign in_free     = s_tdata[212:182];
    assign in_buffers  = s_tdata[243:213];
    assign in_cached   = s_tdata[274:244];

    assign in_used = (in_anon != '0) ? in_anon : in_resident;
    assign in_eff  = {1'b0, budget_reg} + {1'b0, in_media};

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // capture of the tick figures
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            used_reg    <= in_used;
            eff_reg     <= in_eff;
            proc_ok_reg <= s_tuser[0] && (in_eff != '0) && (in_used != '0);
            avail_reg   <= (in_avail != '0) ? in_avail : sat_sum3(in_free, in_buffers, in_cached);
            total_reg   <= in_total;
            sys_ok_reg  <= s_tuser[1] && (in_total != '0);
        end
    end

    // shared multiplier operand selection
    always_comb
    begin
        unique case (op_reg)
            OP_CRIT_BUD: mul_q = crit_bud_reg;
            OP_MOD_BUD:  mul_q = mod_bud_reg;
            OP_CRIT_AVL: mul_q = crit_avl_reg;
            OP_MOD_AVL:  mul_q = mod_avl_reg;
        endcase
    end

    assign mul_wide = (op_reg == OP_CRIT_BUD || op_reg == OP_MOD_BUD)
                      ? {{(WIDE_W - EFF_W){1'b0}}, eff_reg}
                      : {{(WIDE_W - KB_W){1'b0}}, total_reg};

    always_comb
    begin
        unique case (chunk_reg)
            2'd0:    mul_chunk = mul_wide[CHUNK_W-1:0];
            2'd1:    mul_chunk = mul_wide[2*CHUNK_W-1:CHUNK_W];
            2'd2:    mul_chunk = mul_wide[3*CHUNK_W-1:2*CHUNK_W];
            default: mul_chunk = '0;
        endcase
    end

    assign mul_prod = PROD_W'({{CHUNK_W{1'b0}}, mul_q} * {{Q16_W{1'b0}}, mul_chunk});

    // partial product aligned to its chunk; the true sum fits the accumulator
    always_comb
    begin
        unique case (chunk_reg)
            2'd0:    partial = {{(ACC_W - PROD_W){1'b0}}, prod_reg};
            2'd1:    partial = {{(ACC_W - PROD_W - CHUNK_W){1'b0}}, prod_reg, {CHUNK_W{1'b0}}};
            2'd2:    partial = {prod_reg[ACC_W-2*CHUNK_W-1:0], {(2*CHUNK_W){1'b0}}};
            default: partial = '0;
        endcase
    end

    // shared compare: scaled usage or availability against the product
    assign cmp_lhs = (op_reg == OP_CRIT_BUD || op_reg == OP_MOD_BUD)
                     ? {{(ACC_W - BYTES_W - CHUNK_W){1'b0}}, used_reg, {CHUNK_W{1'b0}}}
                     : {{(ACC_W - KB_W - CHUNK_W){1'b0}}, avail_reg, {CHUNK_W{1'b0}}};
    assign cmp_ge  = (cmp_lhs >= acc_reg);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        chunk_next = chunk_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_MUL;
                    op_next    = OP_CRIT_BUD;
                    chunk_next = 2'd0;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (chunk_reg == LAST_CHUNK)
                    state_next = ST_CMP;
                else
                begin
                    chunk_next = chunk_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_CMP:
            begin
                chunk_next = 2'd0;
                if (op_reg == OP_MOD_AVL)
                    state_next = ST_DONE;
                else
                begin
                    op_next    = op_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_CRIT_BUD;
            chunk_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            chunk_reg <= chunk_next;
        end
    end

    // multiply, accumulate and compare datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
            prod_reg <= mul_prod;
        if (in_xfer || state_reg == ST_CMP)
            acc_reg <= '0;
        else if (state_reg == ST_ACC)
            acc_reg <= acc_reg + partial;
        if (state_reg == ST_CMP)
            ge_reg[op_reg] <= cmp_ge;
    end

    // level decision
    always_comb
    begin
        priority if (!proc_ok_reg)
            proc_level = LVL_NONE;
        else if (ge_reg[OP_CRIT_BUD])
            proc_level = LVL_CRITICAL;
        else if (ge_reg[OP_MOD_BUD])
            proc_level = LVL_MODERATE;
        else
            proc_level = LVL_NONE;

        priority if (!sys_ok_reg)
            sys_level = LVL_NONE;
        else if (!ge_reg[OP_CRIT_AVL])
            sys_level = LVL_CRITICAL;
        else if (!ge_reg[OP_MOD_AVL])
            sys_level = LVL_MODERATE;
        else
            sys_level = LVL_NONE;
    end

    assign vote         = (proc_level > sys_level) ? proc_level : sys_level;
    assign cooldown_eff = (cooldown_reg == '0) ? CD_W'(1) : cooldown_reg;
    assign repeat_inc   = repeat_count_reg + CD_W'(1);

    // notification and cooldown counting
    always_comb
    begin
        notify            = 1'b0;
        repeat_count_next = '0;
        priority if (vote == LVL_NONE)
            repeat_count_next = '0;
        else if (vote != last_level_reg)
            notify = 1'b1;
        else if (repeat_inc >= cooldown_eff)
            notify = 1'b1;
        else
            repeat_count_next = repeat_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg   <= LVL_NONE;
            repeat_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                last_level_reg   <= vote;
                repeat_count_reg <= repeat_count_next;
                out_valid_reg    <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_level_reg  <= vote;
            out_notify_reg <= notify;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - LEVEL_W - 1){1'b0}}, out_notify_reg, out_level_reg};

    // configuration writes
    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_ADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg   <= '0;
            mod_bud_reg  <= '0;
            crit_bud_reg <= '0;
            mod_avl_reg  <= '0;
            crit_avl_reg <= '0;
            cooldown_reg <= CD_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_BUDGET:       budget_reg   <= pwdata[BYTES_W-1:0];
                REG_MODERATE_BUD: mod_bud_reg  <= pwdata[Q16_W-1:0];
                REG_CRITICAL_BUD: crit_bud_reg <= pwdata[Q16_W-1:0];
                REG_MODERATE_AVL: mod_avl_reg  <= pwdata[Q16_W-1:0];
                REG_CRITICAL_AVL: crit_avl_reg <= pwdata[Q16_W-1:0];
                REG_COOLDOWN:     cooldown_reg <= pwdata[CD_W-1:0];
                default:          ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (cfg_idx)
            REG_BUDGET:       prdata = {{(APB_DATA_W - BYTES_W){1'b0}}, budget_reg};
            REG_MODERATE_BUD: prdata = {{(APB_DATA_W - Q16_W){1'b0}}, mod_bud_reg};
            REG_CRITICAL_BUD: prdata = {{(APB_DATA_W - Q16_W){1'b0}}, crit_bud_reg};
            REG_MODERATE_AVL: prdata = {{(APB_DATA_W - Q16_W){1'b0}}, mod_avl_reg};
            REG_CRITICAL_AVL: prdata = {{(APB_DATA_W - Q16_W){1'b0}}, crit_avl_reg};
            REG_COOLDOWN:     prdata = {{(APB_DATA_W - CD_W){1'b0}}, cooldown_reg};
            default:          prdata = '0;
        endcase
    end

    // checks
    `include "memory_pressure_vote_monitor_assert.svh"

    `MPVM_ASSERT_NEXT(a_accept_starts_work, clk, rst_n, in_xfer, state_reg == ST_MUL && !s_tready)
    `MPVM_ASSERT_NOW(a_notify_needs_vote, clk, rst_n, out_valid_reg && out_notify_reg, out_level_reg != LVL_NONE)
    `MPVM_ASSERT_NOW(a_idle_vote_clears_count, clk, rst_n, last_level_reg == LVL_NONE, repeat_count_reg == '0)
    `MPVM_ASSERT_NOW(a_chunk_in_range, clk, rst_n, state_reg == ST_MUL || state_reg == ST_ACC, chunk_reg <= LAST_CHUNK)

endmodule

// ----- tb/memory_pressure_vote_monitor_tb.sv -----
`timescale 1ns / 1ps

module memory_pressure_vote_monitor_tb;
    import mpvm_pkg::*;

    localparam int          PAD_W        = IN_DATA_W - 3 * BYTES_W - 5 * KB_W;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          PHASES       = 10;
    localparam int          PHASE_POLLS  = 65;
    localparam logic [2:0]  REG_UNUSED   = 3'd6;
    localparam logic [63:0] BYTES_MAX    = 64'hFF_FFFF_FFFF;
    localparam logic [63:0] KB_MAX       = 64'h7FFF_FFFF;

    // one poll tick as the block sees it
    typedef struct {
        logic               proc_ok;
        logic [BYTES_W-1:0] anon;
        logic [BYTES_W-1:0] resident;
        logic [BYTES_W-1:0] media;
        logic               sys_ok;
        logic [KB_W-1:0]    total_kb;
        logic [KB_W-1:0]    avail_kb;
        logic [KB_W-1:0]    free_kb;
        logic [KB_W-1:0]    buffers_kb;
        logic [KB_W-1:0]    cached_kb;
    } poll_t;

    typedef struct {
        logic [LEVEL_W-1:0] level;
        logic               notify;
    } vote_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor copy of the registers and the vote state
    logic [BYTES_W-1:0] budget_reg = '0;
    logic [Q16_W-1:0]   mod_bud_reg = '0;
    logic [Q16_W-1:0]   crit_bud_reg = '0;
    logic [Q16_W-1:0]   mod_avl_reg = '0;
    logic [Q16_W-1:0]   crit_avl_reg = '0;
    logic [CD_W-1:0]    cooldown_reg = 16'd1;
    logic [LEVEL_W-1:0] last_vote = LVL_NONE;
    logic [CD_W-1:0]    hold_ticks = '0;

    vote_t pending_votes[$];
    vote_t want_vote;
    int    mismatch_count = 0;
    int    cycle_count = 0;
    int    vote_stall = 0;
    bit    no_idle = 1'b0;

    memory_pressure_vote_monitor DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // vote receiver backpressure, a fresh stall after every transfer
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                vote_stall = no_idle ? 0 : $urandom_range(0, 4);
            if (vote_stall > 0)
            begin
                vote_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("vote mismatch at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // compare each vote transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_votes.size() == 0)
            begin
                report_mismatch("unexpected vote, level", m_tdata[1:0], 0);
            end
            else
            begin
                want_vote = pending_votes.pop_front();
                if (m_tdata[1:0] !== want_vote.level)
                    report_mismatch("level", m_tdata[1:0], want_vote.level);
                if (m_tdata[2] !== want_vote.notify)
                    report_mismatch("notify", m_tdata[2], want_vote.notify);
            end
        end
    end

    // level vote and notify decision for one accepted poll
    function automatic vote_t predict_vote(input poll_t p);
        logic [LEVEL_W-1:0] proc_lvl;
        logic [LEVEL_W-1:0] sys_lvl;
        logic [63:0]        used;
        logic [63:0]        eff;
        logic [63:0]        avail;
        logic [63:0]        lhs;
        logic [CD_W-1:0]    cd;
        vote_t              v;
        // process usage against budget plus allowance
        proc_lvl = LVL_NONE;
        eff = 64'(budget_reg) + 64'(p.media);
        used = (p.anon != '0) ? 64'(p.anon) : 64'(p.resident);
        if (p.proc_ok && eff != 0 && used != 0)
        begin
            lhs = used << 16;
            if (lhs >= 64'(crit_bud_reg) * eff)
                proc_lvl = LVL_CRITICAL;
            else if (lhs >= 64'(mod_bud_reg) * eff)
                proc_lvl = LVL_MODERATE;
        end
        // system available fraction, with the saturating fallback sum
        sys_lvl = LVL_NONE;
        if (p.sys_ok && p.total_kb != '0)
        begin
            avail = 64'(p.avail_kb);
            if (avail == 0)
            begin
                avail = 64'(p.free_kb) + 64'(p.buffers_kb) + 64'(p.cached_kb);
                if (avail > KB_MAX)
                    avail = KB_MAX;
            end
            lhs = avail << 16;
            if (lhs < 64'(crit_avl_reg) * 64'(p.total_kb))
                sys_lvl = LVL_CRITICAL;
            else if (lhs < 64'(mod_avl_reg) * 64'(p.total_kb))
                sys_lvl = LVL_MODERATE;
        end
        v.level = (proc_lvl > sys_lvl) ? proc_lvl : sys_lvl;
        v.notify = 1'b0;
        // change and cooldown repeat
        cd = (cooldown_reg == '0) ? 16'd1 : cooldown_reg;
        if (v.level == LVL_NONE)
        begin
            hold_ticks = '0;
        end
        else if (v.level != last_vote)
        begin
            hold_ticks = '0;
            v.notify = 1'b1;
        end
        else
        begin
            hold_ticks = hold_ticks + 16'd1;
            if (hold_ticks >= cd)
            begin
                hold_ticks = '0;
                v.notify = 1'b1;
            end
        end
        last_vote = v.level;
        return v;
    endfunction

    // one apb write, setup then access, then the bus idle again
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BUDGET:       budget_reg   = value[BYTES_W-1:0];
            REG_MODERATE_BUD: mod_bud_reg  = value[Q16_W-1:0];
            REG_CRITICAL_BUD: crit_bud_reg = value[Q16_W-1:0];
            REG_MODERATE_AVL: mod_avl_reg  = value[Q16_W-1:0];
            REG_CRITICAL_AVL: crit_avl_reg = value[Q16_W-1:0];
            REG_COOLDOWN:     cooldown_reg = value[CD_W-1:0];
            default:          ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [63:0] budget, input logic [63:0] mod_bud,
                                  input logic [63:0] crit_bud, input logic [63:0] mod_avl,
                                  input logic [63:0] crit_avl, input logic [63:0] cooldown);
        write_reg(REG_BUDGET, budget);
        write_reg(REG_MODERATE_BUD, mod_bud);
        write_reg(REG_CRITICAL_BUD, crit_bud);
        write_reg(REG_MODERATE_AVL, mod_avl);
        write_reg(REG_CRITICAL_AVL, crit_avl);
        write_reg(REG_COOLDOWN, cooldown);
    endtask

    // send one poll, keeping tvalid high when the next follows at once
    task automatic send_poll(input poll_t p);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, p.cached_kb, p.buffers_kb, p.free_kb, p.avail_kb,
                     p.total_kb, p.media, p.resident, p.anon};
        s_tuser  <= {p.sys_ok, p.proc_ok};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_votes.push_back(predict_vote(p));
    endtask

    // stop sending and let every vote come back
    task automatic drain_votes();
        s_tvalid <= 1'b0;
        while (pending_votes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic poll_t make_poll(input logic proc_ok, input logic [63:0] anon,
                                        input logic [63:0] resident, input logic [63:0] media,
                                        input logic sys_ok, input logic [63:0] total_kb,
                                        input logic [63:0] avail_kb, input logic [63:0] free_kb,
                                        input logic [63:0] buffers_kb,
                                        input logic [63:0] cached_kb);
        poll_t p;
        p.proc_ok    = proc_ok;
        p.anon       = anon[BYTES_W-1:0];
        p.resident   = resident[BYTES_W-1:0];
        p.media      = media[BYTES_W-1:0];
        p.sys_ok     = sys_ok;
        p.total_kb   = total_kb[KB_W-1:0];
        p.avail_kb   = avail_kb[KB_W-1:0];
        p.free_kb    = free_kb[KB_W-1:0];
        p.buffers_kb = buffers_kb[KB_W-1:0];
        p.cached_kb  = cached_kb[KB_W-1:0];
        return p;
    endfunction

    function automatic logic [BYTES_W-1:0] rand_bytes();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return r[BYTES_W-1:0];
            default: return r[BYTES_W-1:0] >> $urandom_range(8, 39);
        endcase
    endfunction

    function automatic logic [KB_W-1:0] rand_kb();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return r[KB_W-1:0];
            default: return r[KB_W-1:0] >> $urandom_range(4, 30);
        endcase
    endfunction

    // random poll, mostly placed near the current thresholds
    function automatic poll_t random_poll();
        poll_t       p;
        logic [63:0] eff;
        logic [63:0] used;
        logic [63:0] est;
        p.proc_ok = ($urandom_range(0, 9) != 0);
        p.sys_ok  = ($urandom_range(0, 9) != 0);
        p.media   = ($urandom_range(0, 2) == 0) ? rand_bytes() : '0;
        eff = 64'(budget_reg) + 64'(p.media);
        if ($urandom_range(0, 3) != 0)
        begin
            used = (eff * 64'($urandom_range(0, 'h14000))) >> 16;
            if (used > BYTES_MAX)
                used = BYTES_MAX;
        end
        else
        begin
            used = 64'(rand_bytes());
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                p.anon     = used[BYTES_W-1:0];
                p.resident = rand_bytes();
            end
            5, 6, 7, 8:
            begin
                p.anon     = '0;
                p.resident = used[BYTES_W-1:0];
            end
            default:
            begin
                p.anon     = '0;
                p.resident = '0;
            end
        endcase
        // system side, direct or through the fallback terms
        p.total_kb = rand_kb();
        est = (64'(p.total_kb) * 64'($urandom_range(0, 'h12000))) >> 16;
        if (est > KB_MAX)
            est = KB_MAX;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                p.avail_kb   = est[KB_W-1:0];
                p.free_kb    = rand_kb();
                p.buffers_kb = rand_kb();
                p.cached_kb  = rand_kb();
            end
            6, 7, 8:
            begin
                p.avail_kb   = '0;
                p.free_kb    = est[KB_W:1];
                p.buffers_kb = est[KB_W+1:2];
                p.cached_kb  = est[KB_W-1:0] - est[KB_W:1] - est[KB_W+1:2];
            end
            default:
            begin
                p.avail_kb   = '0;
                p.free_kb    = rand_kb();
                p.buffers_kb = rand_kb();
                p.cached_kb  = rand_kb();
            end
        endcase
        return p;
    endfunction

    task automatic randomize_thresholds();
        logic [63:0] r;
        logic [63:0] budget;
        logic [63:0] cooldown;
        logic [16:0] mb;
        logic [16:0] cb;
        logic [16:0] ma;
        logic [16:0] ca;
        logic [16:0] t;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0:       budget = 0;
            1:       budget = BYTES_MAX;
            2:       budget = r & BYTES_MAX;
            default: budget = (r & BYTES_MAX) >> $urandom_range(4, 30);
        endcase
        mb = 17'($urandom_range(0, 65536));
        cb = 17'($urandom_range(0, 65536));
        ma = 17'($urandom_range(0, 65536));
        ca = 17'($urandom_range(0, 65536));
        case ($urandom_range(0, 5))
            0:
            begin
                // ratios past 1.0
                mb = 17'($urandom_range(0, 'h1FFFF));
                cb = 17'($urandom_range(0, 'h1FFFF));
                ma = 17'($urandom_range(0, 'h1FFFF));
                ca = 17'($urandom_range(0, 'h1FFFF));
            end
            1:
            begin
                // unordered, critical may sit on the wrong side of moderate
            end
            default:
            begin
                if (mb > cb)
                begin
                    t = mb;
                    mb = cb;
                    cb = t;
                end
                if (ca > ma)
                begin
                    t = ca;
                    ca = ma;
                    ma = t;
                end
            end
        endcase
        case ($urandom_range(0, 5))
            0:       cooldown = 0;
            1:       cooldown = 64'hFFFF;
            2:       cooldown = 64'($urandom_range(0, 'hFFFF));
            default: cooldown = 64'($urandom_range(1, 4));
        endcase
        set_thresholds(budget, 64'(mb), 64'(cb), 64'(ma), 64'(ca), cooldown);
    endtask

    // registers at their reset values: any usage against a nonzero allowance is critical, cooldown one
    task automatic test_reset_defaults();
        send_poll(make_poll(1, 100, 0, 0, 1, 100, 50, 0, 0, 0));
        send_poll(make_poll(1, 1, 0, 1000, 0, 0, 0, 0, 0, 0));
        send_poll(make_poll(1, 1, 0, 1000, 0, 0, 0, 0, 0, 0));
        drain_votes();
    endtask

    // process ratio edges, resident fallback and missing figures
    task automatic test_process_level();
        set_thresholds(1000, 'h8000, 'hC000, 'h4000, 'h1000, 3);
        send_poll(make_poll(0, 900, 0, 0, 0, 0, 0, 0, 0, 0));
        send_poll(make_poll(1, 499, 0, 0, 0, 0, 0, 0, 0, 0));
        send_poll(make_poll(1, 500, 0, 0, 0, 0, 0, 0, 0, 0));
        send_poll(make_poll(1, 0, 750, 0, 0, 0, 0, 0, 0, 0));
        send_poll(make_poll(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_poll(make_poll(1, BYTES_MAX, BYTES_MAX, BYTES_MAX, 0, 0, 0, 0, 0, 0));
        drain_votes();
    endtask

    // available fraction edges, zero total and the saturating sum
    task automatic test_system_level();
        send_poll(make_poll(0, 0, 0, 0, 0, 1000, 1, 0, 0, 0));
        send_poll(make_poll(0, 0, 0, 0, 1, 0, 1, 0, 0, 0));
        send_poll(make_poll(0, 0, 0, 0, 1, 1000, 250, 0, 0, 0));
        send_poll(make_poll(0, 0, 0, 0, 1, 1000, 249, 0, 0, 0));
        send_poll(make_poll(0, 0, 0, 0, 1, 1000, 0, 20, 20, 21));
        send_poll(make_poll(0, 0, 0, 0, 1, KB_MAX, 0, KB_MAX, 1, 0));
        send_poll(make_poll(1, 600, 0, 0, 1, KB_MAX, 0, KB_MAX, KB_MAX, KB_MAX));
        send_poll(make_poll(1, 600, 0, 0, 1, 1000, 10, 0, 0, 0));
        drain_votes();
    endtask

    // repeats at a held level, cooldown lowered mid count, zero cooldown
    task automatic test_cooldown();
        write_reg(REG_COOLDOWN, 5);
        repeat (4) send_poll(make_poll(1, 900, 0, 0, 0, 0, 0, 0, 0, 0));
        drain_votes();
        write_reg(REG_COOLDOWN, 2);
        send_poll(make_poll(1, 900, 0, 0, 0, 0, 0, 0, 0, 0));
        drain_votes();
        write_reg(REG_COOLDOWN, 0);
        repeat (2) send_poll(make_poll(1, 900, 0, 0, 0, 0, 0, 0, 0, 0));
        drain_votes();
    endtask

    // widest register values, moderate above critical, unmapped register
    task automatic test_threshold_extremes();
        set_thresholds(BYTES_MAX, 'h1FFFF, 'h10000, 0, 'h1FFFF, 'hFFFF);
        write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_poll(make_poll(1, BYTES_MAX, 0, 0, 1, 1, KB_MAX, 0, 0, 0));
        send_poll(make_poll(1, BYTES_MAX >> 1, 0, 0, 1, KB_MAX, 1, 0, 0, 0));
        drain_votes();
        write_reg(REG_BUDGET, 0);
        send_poll(make_poll(1, BYTES_MAX, BYTES_MAX, 0, 0, 0, 0, 0, 0, 0));
        drain_votes();
    endtask

    // random phases, each with its own register setting
    task automatic test_random_polls();
        poll_t p;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_votes();
            randomize_thresholds();
            no_idle = (phase % 3 == 2);
            p = random_poll();
            for (int n = 0; n < PHASE_POLLS; n++)
            begin
                // repeating a poll tends to hold the level for the cooldown
                if ($urandom_range(0, 9) >= 4)
                    p = random_poll();
                send_poll(p);
            end
        end
        drain_votes();
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_process_level();
        test_system_level();
        test_cooldown();
        test_threshold_extremes();
        test_random_polls();
        if (mismatch_count == 0 && pending_votes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/mpvm_pkg.sv
src/memory_pressure_vote_monitor.sv
tb/memory_pressure_vote_monitor_tb.sv
